FILE: sv/egsd_pkg.sv
`timescale 1ns / 1ps
package egsd_pkg;

	localparam int DEPTH  = 1024;
	localparam int DLY_W  = 24;
	localparam int DEV_W  = 17;
	localparam int PROD_W = 33;
	localparam int VEG_W  = PROD_W - 8;

	typedef enum logic [2:0] {
		CFG_EDGE_CENTER = 3'd0,
		CFG_SAT_LIMIT   = 3'd1,
		CFG_SAT_LEVEL   = 3'd2,
		CFG_EDGE_GAIN   = 3'd3,
		CFG_DELAY_SCALE = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic             adv;
		logic [15:0]      wdata;
		logic [DLY_W-1:0] delay;
	} hist_req_t;

endpackage

FILE: sv/egsd_hist.sv
`timescale 1ns / 1ps
module egsd_hist #(
	parameter int DEPTH = egsd_pkg::DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  egsd_pkg::hist_req_t req,
	output logic [15:0]         rdata_s3,
	output logic                hit_s3
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam int DW = egsd_pkg::DLY_W;

	logic [15:0]   mem [DEPTH];
	logic [AW-1:0] wp_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] fill_nx;
	logic [DW-1:0] fill_ext;
	logic [DW-1:0] dm1;
	logic [AW-1:0] back;
	logic [AW:0]   wrap_sum;
	logic [AW-1:0] idx;
	logic          hit;

	always_comb begin
		fill_nx  = (fill_q == FW'(DEPTH)) ? fill_q : fill_q + FW'(1);
		fill_ext = DW'(fill_nx);
		dm1      = req.delay - DW'(1);
		back     = dm1[AW-1:0];
		// back of zero is the word written now, taken from the bypass instead
		hit      = (req.delay > DW'(1)) && (req.delay < fill_ext);
		wrap_sum = {1'b0, wp_q} + (AW + 1)'(DEPTH) - {1'b0, back};
		idx      = (wp_q >= back) ? (wp_q - back) : wrap_sum[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (req.adv) begin
			mem[wp_q] <= req.wdata;
			rdata_s3  <= mem[idx];
			hit_s3    <= hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (req.adv) begin
			wp_q   <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			fill_q <= fill_nx;
		end
	end

endmodule

FILE: sv/edge_guide_saturating_delay_model.sv
`timescale 1ns / 1ps
// channel  dir  handshake         payload
// s        in   s_tvalid/tready   s_tdata: sensor_volts [15:0], idler_period [31:16]
// m        out  m_tvalid/tready   m_tdata: guide_volts [15:0]
// cfg      in   cfg_we            cfg_addr register index, cfg_wdata value
//
// one word in and one word out per cycle while m_tready holds; an accepted word passes in turn through
// the offset stage, multiply stage, clamp and history memory read stage and output register
// each stage holds its word under stall and empty stages fill up, so input keeps
// flowing until every stage is full
// arst_n clears the valid bits, history pointer, fill count and config registers to reset values
module edge_guide_saturating_delay_model #(
	parameter int DEPTH = egsd_pkg::DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // sensor_volts, idler_period
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // guide_volts
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	localparam int DEV_W  = egsd_pkg::DEV_W;
	localparam int PROD_W = egsd_pkg::PROD_W;
	localparam int VEG_W  = egsd_pkg::VEG_W;
	localparam int DW     = egsd_pkg::DLY_W;

	logic signed [15:0] edge_center_q;
	logic [14:0]        sat_limit_q;
	logic [14:0]        sat_level_q;
	logic signed [15:0] edge_gain_q;
	logic [15:0]        delay_scale_q;

	logic                    valid_s1, valid_s2, valid_s3, out_valid_q;
	logic                    adv1, adv2, adv3, adv_out;
	logic signed [DEV_W-1:0] dev_in;
	logic signed [DEV_W-1:0] dev_s1;
	logic [15:0]             period_s1;
	logic signed [DEV_W-1:0] lim;
	logic signed [PROD_W-1:0] prod;
	logic [31:0]             dprod;
	logic signed [PROD_W-1:0] prod_s2;
	logic [DW-1:0]           delay_s2;
	logic                    hi_s2, lo_s2;
	logic signed [VEG_W-1:0] scaled, lvl, veg;
	logic signed [15:0]      veg_s3;
	logic [15:0]             out_q;
	logic [15:0]             rdata_s3;
	logic                    hit_s3;
	egsd_pkg::hist_req_t     req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_center_q <= '0;
			sat_limit_q   <= '0;
			sat_level_q   <= '0;
			edge_gain_q   <= 16'sd256;
			delay_scale_q <= '0;
		end else if (cfg_we) begin
			case (egsd_pkg::cfg_idx_t'(cfg_addr))
				egsd_pkg::CFG_EDGE_CENTER: edge_center_q <= cfg_wdata;
				egsd_pkg::CFG_SAT_LIMIT:   sat_limit_q   <= cfg_wdata[14:0];
				egsd_pkg::CFG_SAT_LEVEL:   sat_level_q   <= cfg_wdata[14:0];
				egsd_pkg::CFG_EDGE_GAIN:   edge_gain_q   <= cfg_wdata;
				egsd_pkg::CFG_DELAY_SCALE: delay_scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign adv_out  = !out_valid_q || m_tready;
	assign adv3     = !valid_s3 || adv_out;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign s_tready = adv1;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1)    valid_s1    <= s_tvalid;
			if (adv2)    valid_s2    <= valid_s1;
			if (adv3)    valid_s3    <= valid_s2;
			if (adv_out) out_valid_q <= valid_s3;
		end
	end

	// deviation from center, full 17 bits
	assign dev_in = $signed({s_tdata[15], s_tdata[15:0]})
		- $signed({edge_center_q[15], edge_center_q});

	always_ff @(posedge clk) begin
		if (adv1) begin
			dev_s1    <= dev_in;
			period_s1 <= s_tdata[31:16];
		end
	end

	always_comb begin
		lim   = $signed({2'b00, sat_limit_q});
		prod  = dev_s1 * edge_gain_q;
		dprod = period_s1 * delay_scale_q;
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			prod_s2  <= prod;
			delay_s2 <= dprod[31:8];
			hi_s2    <= dev_s1 > lim;
			lo_s2    <= dev_s1 < -lim;
		end
	end

	// floor shift, then clamp to the saturation level; a deviation beyond the saturation limit forces the level
	always_comb begin
		scaled = prod_s2[PROD_W-1:8];
		lvl    = $signed({{(VEG_W - 15){1'b0}}, sat_level_q});
		if (hi_s2) begin
			veg = lvl;
		end else if (lo_s2) begin
			veg = -lvl;
		end else if (scaled > lvl) begin
			veg = lvl;
		end else if (scaled < -lvl) begin
			veg = -lvl;
		end else begin
			veg = scaled;
		end
	end

	always_comb begin
		req.adv   = valid_s2 && adv3;
		req.wdata = veg[15:0];
		req.delay = delay_s2;
	end

	egsd_hist #(
		.DEPTH(DEPTH)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rdata_s3(rdata_s3),
		.hit_s3  (hit_s3)
	);

	always_ff @(posedge clk) begin
		if (adv3) veg_s3 <= veg[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv_out) out_q <= hit_s3 ? rdata_s3 : veg_s3;
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && valid_s3 && out_valid_q))
		else $error("input stalled with an empty stage");

	a_accept_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted word missing from first stage");

	a_out_from_s3: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s3))
		else $error("output valid without a word in the last stage");

endmodule
